/* rtl/core/dbsp_pkg.sv */
package dbsp_pkg;

    // Storage geometry.
    localparam int HALF_DEPTH   = 512;
    localparam int SAMPLE_WIDTH = 16;
    localparam int STORE_DEPTH  = 2 * HALF_DEPTH;
    localparam int ADDR_W       = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    // Field widths fixed by the interface.
    localparam int RAW_W    = 16;
    localparam int BREATH_W = 24;
    localparam int DAC_W    = 12;
    localparam int SPI_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int OFFS_W   = 16;
    localparam int VOL_W    = 10;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 16;

    // The shared divider handles the sample magnitude and the gain numerator.
    localparam int DIV_W     = (SAMPLE_WIDTH + 1 > GAIN_W + 1) ? SAMPLE_WIDTH + 1 : GAIN_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [DAC_W-1:0]  DAC_MAX  = '1;
    localparam logic [SPI_W-1:0]  SPI_FLAG = SPI_W'(1 << 12);

    // Volume smoothing divides a sum of at most 5115 by five as a multiply by
    // 6554 followed by a shift of 15; the result is exact over that range.
    localparam int                SMOOTH_SHIFT = 15;
    localparam logic [VOL_W+2:0]  SMOOTH_RECIP = (VOL_W+3)'(6554);

    // Reset values.
    localparam logic [DAC_W-1:0]  RST_MIDPOINT = DAC_W'(2000);
    localparam logic [GAIN_W-1:0] RST_GAIN     = GAIN_W'(16000);
    localparam logic [OFFS_W-1:0] RST_OFFSET   = OFFS_W'(24);
    localparam logic [VOL_W-1:0]  RST_CEILING  = VOL_W'(1000);
    localparam logic [VOL_W-1:0]  RST_VOLUME   = VOL_W'(100);

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_BREATH = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [CFG_IW-1:0] {
        CFG_MIDPOINT = 2'd0,
        CFG_GAIN     = 2'd1,
        CFG_OFFSET   = 2'd2,
        CFG_CEILING  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_GAIN,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-2:0] divisor;
    } t_div_req;

endpackage

/* rtl/core/dbsp_ram.sv */
module dbsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dbsp_div.sv */
module dbsp_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dbsp_pkg::t_div_req        i_req,
    output logic                      o_done,
    output logic [dbsp_pkg::DIV_W-1:0] o_quotient
);

    // Restoring divider, one quotient bit per cycle.
    logic                               r_busy;
    logic                               r_done;
    logic [dbsp_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [dbsp_pkg::DIV_W-1:0]         r_rem;
    logic [dbsp_pkg::DIV_W-1:0]         r_quo;
    logic [dbsp_pkg::DIV_W-2:0]         r_dvs;
    logic [dbsp_pkg::DIV_W-1:0]         w_trial;
    logic [dbsp_pkg::DIV_W-1:0]         w_diff;
    logic                               w_ge;

    always_comb begin
        w_trial = {r_rem[dbsp_pkg::DIV_W-2:0], r_quo[dbsp_pkg::DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == dbsp_pkg::DIV_CNT_W'(dbsp_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_trial;
            r_quo <= {r_quo[dbsp_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/double_buffered_sample_player_top.sv */
// Double-buffered sample player.
//
// Input items arrive on the slave stream. tuser carries the action (load,
// tick, breath; the fourth code does nothing), and tdata carries the two
// sample bytes and the signed 24-bit breath reading. Every accepted item
// gives exactly one result item on the master stream: tuser says whether
// the result carries a fresh DAC sample, tdata holds the DAC code, the SPI
// word, the refill request and the current smoothed volume.
//
// Work is done one item at a time by a small sequencer around one shared
// restoring divider that produces one quotient bit per cycle while busy. A
// load, a breath item or an unused action passes through the execute and
// done states and then into the output register, after which the sequencer
// is idle again and the next item can be taken. A tick runs two chained
// divisions (gain over volume, then sample magnitude over that quotient);
// if the volume or the first quotient is zero it plays the midpoint after
// the first division. The slave side is ready only while the sequencer is
// idle.
//
// After reset the sample store is cleared one entry per cycle, and no
// input item is accepted meanwhile; configuration writes are taken at any
// time. A finished result sits in the output register until the receiver
// takes it, and the next item may be accepted while it waits; a further
// result waits in the sequencer until the output register is free.
module double_buffered_sample_player_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Slave stream.
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // tdata fields from bit 0: sample_low_byte[7:0], sample_high_byte[15:8],
    // breath_reading[39:16].
    input  logic [39:0]                  i_s_tdata,
    // tuser fields from bit 0: action[1:0].
    input  logic [1:0]                   i_s_tuser,
    // Master stream.
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // tdata fields from bit 0: dac_code[11:0], spi_word[27:12],
    // refill_request[28], volume_now[38:29], zero fill [39].
    output logic [39:0]                  o_m_tdata,
    // tuser fields from bit 0: dac_valid[0].
    output logic [0:0]                   o_m_tuser,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dbsp_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [dbsp_pkg::CFG_DW-1:0]  i_cfg_data
);

    localparam int LVL_W = dbsp_pkg::DIV_W + 2;

    // Sequencer and item registers.
    dbsp_pkg::t_state                     r_state, n_state;
    logic [dbsp_pkg::STORE_AW-1:0]        r_clr_addr, n_clr_addr;
    dbsp_pkg::t_action                    r_action, n_action;
    logic [dbsp_pkg::RAW_W-1:0]           r_raw, n_raw;
    logic [dbsp_pkg::BREATH_W-1:0]        r_breath, n_breath;

    // Player state.
    logic                                 r_half, n_half;
    logic [dbsp_pkg::ADDR_W-1:0]          r_pos, n_pos;
    logic [dbsp_pkg::ADDR_W-1:0]          r_lp, n_lp;
    logic                                 r_refill, n_refill;
    logic [dbsp_pkg::VOL_W-1:0]           r_vol, n_vol;

    // Configuration registers.
    logic [dbsp_pkg::DAC_W-1:0]           r_mid;
    logic [dbsp_pkg::GAIN_W-1:0]          r_gain;
    logic [dbsp_pkg::OFFS_W-1:0]          r_boff;
    logic [dbsp_pkg::VOL_W-1:0]           r_bceil;

    // Result under construction and the output register.
    logic [dbsp_pkg::STORE_AW-1:0]        r_rd_addr, n_rd_addr;
    logic [dbsp_pkg::DAC_W-1:0]           r_code, n_code;
    logic                                 r_tick, n_tick;
    logic                                 r_out_valid, n_out_valid;
    logic [0:0]                           r_out_user, n_out_user;
    logic [39:0]                          r_out_data, n_out_data;

    // Memory and divider hookup.
    logic                                 w_we;
    logic [dbsp_pkg::STORE_AW-1:0]        w_waddr;
    logic [dbsp_pkg::SAMPLE_WIDTH-1:0]    w_wdata;
    logic [dbsp_pkg::SAMPLE_WIDTH-1:0]    w_rdata;
    dbsp_pkg::t_div_req                   w_div_req;
    logic                                 w_div_done;
    logic [dbsp_pkg::DIV_W-1:0]           w_quo;

    // Datapath helpers.
    logic [dbsp_pkg::RAW_W+dbsp_pkg::SAMPLE_WIDTH-1:0] w_raw_ext;
    logic [dbsp_pkg::ADDR_W-1:0]          w_offset;
    logic                                 w_neg;
    logic [dbsp_pkg::DIV_W-1:0]           w_samp_ext;
    logic [dbsp_pkg::DIV_W-1:0]           w_mag;
    logic signed [LVL_W-1:0]              w_sq;
    logic signed [LVL_W-1:0]              w_level;
    logic signed [dbsp_pkg::BREATH_W:0]   w_x;
    logic [dbsp_pkg::VOL_W-1:0]           w_x_clamp;
    logic [dbsp_pkg::VOL_W+2:0]           w_sum;
    logic [2*(dbsp_pkg::VOL_W+3)-1:0]     w_smooth;
    logic                                 w_in_acc;
    logic                                 w_out_free;
    logic [dbsp_pkg::SPI_W-1:0]           w_spi;

    dbsp_ram #(
        .WIDTH (dbsp_pkg::SAMPLE_WIDTH),
        .DEPTH (dbsp_pkg::STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    dbsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_s_tready  = (r_state == dbsp_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // Sample arithmetic: the stored word is a two's complement sample, and
    // the divider works on its magnitude so the quotient truncates toward zero.
    always_comb begin
        w_raw_ext  = {{dbsp_pkg::SAMPLE_WIDTH{1'b0}}, r_raw};
        w_offset   = dbsp_pkg::ADDR_W'(dbsp_pkg::HALF_DEPTH - 1) - r_pos;
        w_neg      = w_rdata[dbsp_pkg::SAMPLE_WIDTH-1];
        w_samp_ext = {{(dbsp_pkg::DIV_W - dbsp_pkg::SAMPLE_WIDTH){w_neg}}, w_rdata};
        w_mag      = w_neg ? (~w_samp_ext + 1'b1) : w_samp_ext;
        w_sq       = w_neg ? -$signed({2'b00, w_quo}) : $signed({2'b00, w_quo});
        w_level    = $signed({{(LVL_W - dbsp_pkg::DAC_W){1'b0}}, r_mid}) + w_sq;

        // Breath target: reading minus offset, held to 0..ceiling.
        w_x = $signed({r_breath[dbsp_pkg::BREATH_W-1], r_breath})
            - $signed({{(dbsp_pkg::BREATH_W + 1 - dbsp_pkg::OFFS_W){1'b0}}, r_boff});
        if (w_x < 0) begin
            w_x_clamp = '0;
        end else if (w_x > $signed({{(dbsp_pkg::BREATH_W + 1 - dbsp_pkg::VOL_W){1'b0}},
                                    r_bceil})) begin
            w_x_clamp = r_bceil;
        end else begin
            w_x_clamp = w_x[dbsp_pkg::VOL_W-1:0];
        end
        w_sum = {1'b0, r_vol, 2'b00} + {3'b000, w_x_clamp};
        // The smoothed volume is the sum divided by five, by reciprocal multiply.
        w_smooth = w_sum * dbsp_pkg::SMOOTH_RECIP;

        w_spi = dbsp_pkg::SPI_W'(r_code) | (r_tick ? dbsp_pkg::SPI_FLAG : '0);
    end

    // Next state and outputs of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_action    = r_action;
        n_raw       = r_raw;
        n_breath    = r_breath;
        n_half      = r_half;
        n_pos       = r_pos;
        n_lp        = r_lp;
        n_refill    = r_refill;
        n_vol       = r_vol;
        n_rd_addr   = r_rd_addr;
        n_code      = r_code;
        n_tick      = r_tick;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = (r_half ? '0 : dbsp_pkg::STORE_AW'(dbsp_pkg::HALF_DEPTH))
                    + dbsp_pkg::STORE_AW'(r_lp);
        w_wdata     = w_raw_ext[dbsp_pkg::SAMPLE_WIDTH-1:0];
        w_div_req   = '0;

        case (r_state)
            dbsp_pkg::ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == dbsp_pkg::STORE_AW'(dbsp_pkg::STORE_DEPTH - 1)) begin
                    n_state = dbsp_pkg::ST_IDLE;
                end
            end
            dbsp_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_action = dbsp_pkg::t_action'(i_s_tuser);
                    n_raw    = i_s_tdata[15:0];
                    n_breath = i_s_tdata[39:16];
                    n_state  = dbsp_pkg::ST_EXEC;
                end
            end
            dbsp_pkg::ST_EXEC: begin
                n_code = '0;
                n_tick = 1'b0;
                case (r_action)
                    dbsp_pkg::ACT_LOAD: begin
                        w_we = 1'b1;
                        if (r_lp == dbsp_pkg::ADDR_W'(dbsp_pkg::HALF_DEPTH - 1)) begin
                            n_lp     = '0;
                            n_refill = 1'b0;
                        end else begin
                            n_lp = r_lp + 1'b1;
                        end
                        n_state = dbsp_pkg::ST_DONE;
                    end
                    dbsp_pkg::ACT_TICK: begin
                        n_tick    = 1'b1;
                        n_rd_addr = (r_half ? dbsp_pkg::STORE_AW'(dbsp_pkg::HALF_DEPTH) : '0)
                                  + dbsp_pkg::STORE_AW'(w_offset);
                        // Position bookkeeping does not depend on the arithmetic.
                        if (r_pos == '0) begin
                            n_half   = !r_half;
                            n_pos    = dbsp_pkg::ADDR_W'(dbsp_pkg::HALF_DEPTH - 1);
                            n_refill = 1'b1;
                            n_lp     = '0;
                        end else begin
                            n_pos = r_pos - 1'b1;
                        end
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = dbsp_pkg::DIV_W'(r_gain);
                        w_div_req.divisor  = (dbsp_pkg::DIV_W-1)'(r_vol);
                        n_state = dbsp_pkg::ST_GAIN;
                    end
                    dbsp_pkg::ACT_BREATH: begin
                        n_vol   = w_smooth[dbsp_pkg::SMOOTH_SHIFT +: dbsp_pkg::VOL_W];
                        n_state = dbsp_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = dbsp_pkg::ST_DONE;
                    end
                endcase
            end
            dbsp_pkg::ST_GAIN: begin
                if (w_div_done) begin
                    if (r_vol == '0 || w_quo == '0) begin
                        // No usable divisor: play the centre level.
                        n_code  = r_mid;
                        n_state = dbsp_pkg::ST_DONE;
                    end else begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = w_mag;
                        w_div_req.divisor  = w_quo[dbsp_pkg::DIV_W-2:0];
                        n_state = dbsp_pkg::ST_SCALE;
                    end
                end
            end
            dbsp_pkg::ST_SCALE: begin
                if (w_div_done) begin
                    if (w_level < 0) begin
                        n_code = '0;
                    end else if (w_level > $signed(LVL_W'(dbsp_pkg::DAC_MAX))) begin
                        n_code = dbsp_pkg::DAC_MAX;
                    end else begin
                        n_code = w_level[dbsp_pkg::DAC_W-1:0];
                    end
                    n_state = dbsp_pkg::ST_DONE;
                end
            end
            dbsp_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_tick;
                    n_out_data  = {1'b0, r_vol, r_refill, w_spi, r_code};
                    n_state     = dbsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dbsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dbsp_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_half      <= 1'b0;
            r_pos       <= dbsp_pkg::ADDR_W'(dbsp_pkg::HALF_DEPTH - 1);
            r_lp        <= '0;
            r_refill    <= 1'b0;
            r_vol       <= dbsp_pkg::RST_VOLUME;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_half      <= n_half;
            r_pos       <= n_pos;
            r_lp        <= n_lp;
            r_refill    <= n_refill;
            r_vol       <= n_vol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_raw      <= n_raw;
        r_breath   <= n_breath;
        r_rd_addr  <= n_rd_addr;
        r_code     <= n_code;
        r_tick     <= n_tick;
        r_out_user <= n_out_user;
        r_out_data <= n_out_data;
    end

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= dbsp_pkg::RST_MIDPOINT;
            r_gain  <= dbsp_pkg::RST_GAIN;
            r_boff  <= dbsp_pkg::RST_OFFSET;
            r_bceil <= dbsp_pkg::RST_CEILING;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (dbsp_pkg::t_cfg_idx'(i_cfg_index))
                dbsp_pkg::CFG_MIDPOINT: r_mid   <= i_cfg_data[dbsp_pkg::DAC_W-1:0];
                dbsp_pkg::CFG_GAIN:     r_gain  <= i_cfg_data[dbsp_pkg::GAIN_W-1:0];
                dbsp_pkg::CFG_OFFSET:   r_boff  <= i_cfg_data[dbsp_pkg::OFFS_W-1:0];
                dbsp_pkg::CFG_CEILING:  r_bceil <= i_cfg_data[dbsp_pkg::VOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/core/dbsp_chk.sv */
module dbsp_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] o_m_tdata,
    input  logic [0:0]  o_m_tuser
);

    // The store is cleared after reset, so no item may enter right away.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready right after reset");

    // One item at a time: acceptance closes the input side.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input stayed ready after an accepted item");

    // A stalled result holds its value.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // A played sample carries the SPI word built from its code.
    a_spi_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |->
            (o_m_tdata[27:24] == 4'b0001 && o_m_tdata[23:12] == o_m_tdata[11:0]))
        else $error("SPI word does not match the DAC code");

    // Results other than ticks carry no code and no SPI word.
    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[27:0] == 28'd0))
        else $error("non-tick result carries DAC data");

endmodule

bind double_buffered_sample_player_top dbsp_chk u_dbsp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
